// File: src/cldc_pkg.sv
// Shared types and constants for the light/dark colour classifier.
// Used by every module of the block; depends on nothing else.
package cldc_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;

  // Configuration register indexes and reset values
  localparam logic [1:0] CFG_ALPHA_FLOOR = 2'd0;
  localparam logic [1:0] CFG_HUE_SPREAD  = 2'd1;
  localparam logic [1:0] CFG_SAT_SPREAD  = 2'd2;

  localparam logic [7:0]  ALPHA_FLOOR_RST = 8'd75;
  localparam logic [15:0] HUE_SPREAD_RST  = 16'd2560;
  localparam logic [15:0] SAT_SPREAD_RST  = 16'd6553;

  // Palette codes
  localparam logic [1:0] PAL_UNKNOWN = 2'd0;
  localparam logic [1:0] PAL_LIGHT   = 2'd1;
  localparam logic [1:0] PAL_DARK    = 2'd2;

  // Hue in Q9.7 degrees
  localparam int HUE_SIXTH = 7680;
  localparam int HUE_FULL  = 46080;

  localparam int SUM_W = 24;

  // Shared divider: 24-bit dividend, 8-bit divisor, several quotient bits per cycle
  localparam int DIV_W       = 24;
  localparam int DIVISOR_W   = 8;
  localparam int DIV_STEPS   = 3;
  localparam int DIV_CYCLES  = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [31:0] color;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [1:0]  palette;
    logic [15:0] sampled_count;
  } out_t;

  // One prepared colour waiting for the back end
  typedef struct packed {
    logic                 sampled;
    logic                 last;
    logic [7:0]           mx;
    logic [7:0]           d;
    logic [DIV_W-1:0]     hue_num;
  } work_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_W-1:0]     quotient;
  } div_rsp_t;

endpackage

// File: src/cldc_front.sv
// Front end: accepts colours, applies the alpha floor and prepares the
// divider operands (max, spread, hue numerator). Depends on cldc_pkg.
module cldc_front import cldc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] alpha_floor,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  input  logic       q_full,
  output logic       q_push,
  output work_t      q_entry
);

  logic  held;
  work_t entry;
  work_t entry_next;

  logic [7:0]         r, g, b, mx, mn, d;
  logic signed [8:0]  diff;
  logic [2:0]         base_mul;
  logic signed [25:0] num;

  assign in_stall = held && q_full;
  assign q_push   = held && !q_full;
  assign q_entry  = entry;

  always_comb begin
    r = in_data.color[23:16];
    g = in_data.color[15:8];
    b = in_data.color[7:0];
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // red first, then green, then blue
    if (r == mx) begin
      diff     = $signed({1'b0, g}) - $signed({1'b0, b});
      base_mul = 3'd0;
    end else if (g == mx) begin
      diff     = $signed({1'b0, b}) - $signed({1'b0, r});
      base_mul = 3'd2;
    end else begin
      diff     = $signed({1'b0, r}) - $signed({1'b0, g});
      base_mul = 3'd4;
    end
    num = $signed({15'd0, d, 3'd0}) * $signed({23'd0, base_mul}) * 26'sd960
        + $signed({{17{diff[8]}}, diff}) * 26'sd7680;
    // wrap negative hue into range
    if (num < 0) num = num + $signed({18'd0, d}) * 26'(HUE_FULL);
    entry_next.sampled = in_data.color[31:24] >= alpha_floor;
    entry_next.last    = in_data.last;
    entry_next.mx      = mx;
    entry_next.d       = d;
    entry_next.hue_num = num[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (q_push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      entry <= entry_next;
    end
  end

endmodule

// File: src/cldc_queue.sv
// Short queue between the front and back ends.
// Depends on cldc_pkg for the entry type and depth.
module cldc_queue import cldc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_entry,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output work_t head
);

  work_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full       = fill == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// File: src/cldc_div.sv
// Shared restoring divider, several quotient bits per cycle.
// Serves both the saturation and hue divisions. Depends on cldc_pkg.
module cldc_div import cldc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] step_cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIV_W-1:0]     dq;
  logic [DIVISOR_W-1:0] rem_next;
  logic [DIV_W-1:0]     dq_next;

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dq;

  always_comb begin
    logic [DIVISOR_W:0] trial;
    logic               ge;
    rem_next = rem;
    dq_next  = dq;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial    = {rem_next, dq_next[DIV_W-1]};
      ge       = trial >= {1'b0, divisor};
      dq_next  = {dq_next[DIV_W-2:0], ge};
      rem_next = ge ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= busy && !req.start && (step_cnt == DIV_CNT_W'(DIV_CYCLES - 1));
      if (req.start) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (busy) begin
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      dq      <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= dq_next;
    end
  end

endmodule

// File: src/cldc_back.sv
// Back end: runs the two divisions, keeps hue/saturation ranges and the
// brightness sum, and issues the class on the last colour. Depends on cldc_pkg.
module cldc_back import cldc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] hue_spread_limit,
  input  logic [15:0] sat_spread_limit,
  input  logic        head_valid,
  input  work_t       head,
  output logic        pop,
  output div_req_t    div_req,
  input  div_rsp_t    div_rsp,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  localparam int CMP_W = (COUNT_BITS + 8 > SUM_W + 1) ? COUNT_BITS + 8 : SUM_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAT,
    ST_HUE,
    ST_ACC,
    ST_FIN
  } state_t;

  state_t state;
  work_t  cur;
  logic [15:0] sat;
  logic [15:0] hue;

  logic [COUNT_BITS-1:0] sample_count;
  logic [15:0]           hue_low, hue_high, sat_low, sat_high;
  logic [SUM_W-1:0]      value_sum;

  logic [15:0]      sat_next;
  logic [15:0]      hue_next;
  logic [SUM_W:0]   sum_wide;
  logic [CMP_W-1:0] sum2;
  logic [CMP_W-1:0] count255;
  logic [31:0]      count32;
  logic [1:0]       palette_next;
  logic             out_free;

  assign pop      = (state == ST_IDLE) && head_valid;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    div_req.start    = (pop && head.sampled) || (state == ST_SAT && div_rsp.done);
    div_req.dividend = (state == ST_SAT) ? cur.hue_num : {head.d, 16'd0};
    div_req.divisor  = (state == ST_SAT) ? cur.d : head.mx;
  end

  always_comb begin
    if (cur.mx == 8'd0) begin
      sat_next = '0;
    end else if (div_rsp.quotient > DIV_W'(16'hFFFF)) begin
      sat_next = 16'hFFFF;
    end else begin
      sat_next = div_rsp.quotient[15:0];
    end
    hue_next = (cur.d == 8'd0) ? 16'd0 : div_rsp.quotient[15:0];
    sum_wide = {1'b0, value_sum} + (SUM_W + 1)'(cur.mx);
  end

  always_comb begin
    sum2     = CMP_W'({value_sum, 1'b0});
    count255 = CMP_W'({sample_count, 8'd0}) - CMP_W'(sample_count);
    count32  = 32'(sample_count);
    if (sample_count == '0) begin
      palette_next = PAL_UNKNOWN;
    end else if (16'(hue_high - hue_low) > hue_spread_limit ||
                 16'(sat_high - sat_low) > sat_spread_limit) begin
      palette_next = PAL_UNKNOWN;
    end else if (sum2 >= count255) begin
      palette_next = PAL_LIGHT;
    end else begin
      palette_next = PAL_DARK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      sample_count <= '0;
      hue_low      <= '0;
      hue_high     <= '0;
      sat_low      <= '0;
      sat_high     <= '0;
      value_sum    <= '0;
    end else begin
      // a new result in the finish state takes over the output register
      if (out_valid && !out_stall && !(state == ST_FIN && cur.last)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            cur   <= head;
            state <= head.sampled ? ST_SAT : ST_FIN;
          end
        end
        ST_SAT: begin
          if (div_rsp.done) begin
            sat   <= sat_next;
            state <= ST_HUE;
          end
        end
        ST_HUE: begin
          if (div_rsp.done) begin
            hue   <= hue_next;
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (sample_count == '0) begin
            hue_low  <= hue;
            hue_high <= hue;
            sat_low  <= sat;
            sat_high <= sat;
          end else begin
            if (hue < hue_low)  hue_low  <= hue;
            if (hue > hue_high) hue_high <= hue;
            if (sat < sat_low)  sat_low  <= sat;
            if (sat > sat_high) sat_high <= sat;
          end
          // saturated count: ranges still move, sum and count hold
          if (sample_count != '1) begin
            value_sum    <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            sample_count <= sample_count + 1'b1;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!cur.last) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_valid              <= 1'b1;
            out_data.palette       <= palette_next;
            out_data.sampled_count <= (count32 > 32'hFFFF) ? 16'hFFFF : count32[15:0];
            sample_count           <= '0;
            hue_low                <= '0;
            hue_high               <= '0;
            sat_low                <= '0;
            sat_high               <= '0;
            value_sum              <= '0;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/color_light_dark_classifier.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in        in         in_valid / in_stall    in_t  {color, last}
// out       out        out_valid / out_stall  out_t {palette, sampled_count}
//
// A colour that passes the alpha floor goes through the back end in order:
// dequeue, two passes of the shared divider (eight steps and a registered
// done each), accumulate and finish. A colour below the floor is dequeued
// and finished. The front end and a two-entry queue keep accepting while the
// back end works. rst is synchronous: it clears control state, the
// accumulators, and loads the register reset values; there is no clearing
// pass. A stalled result holds the back end on the last colour.
//
// Top level: configuration registers, front end, queue, divider and back end.
// Depends on cldc_pkg and the cldc_* modules.
module color_light_dark_classifier import cldc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  logic [7:0]  alpha_floor;
  logic [15:0] hue_spread_limit;
  logic [15:0] sat_spread_limit;

  logic     q_full;
  logic     q_push;
  work_t    q_entry;
  logic     q_pop;
  logic     q_valid;
  work_t    q_head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_floor      <= ALPHA_FLOOR_RST;
      hue_spread_limit <= HUE_SPREAD_RST;
      sat_spread_limit <= SAT_SPREAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ALPHA_FLOOR: alpha_floor      <= cfg_data[7:0];
        CFG_HUE_SPREAD:  hue_spread_limit <= cfg_data;
        CFG_SAT_SPREAD:  sat_spread_limit <= cfg_data;
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  cldc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .alpha_floor (alpha_floor),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  cldc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  cldc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  cldc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .hue_spread_limit (hue_spread_limit),
    .sat_spread_limit (sat_spread_limit),
    .head_valid       (q_valid),
    .head             (q_head),
    .pop              (q_pop),
    .div_req          (div_req),
    .div_rsp          (div_rsp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_div_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> $past(div_rsp.busy))
    else $error("divider done without a running division");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the light/dark colour classifier.
// Drives colour transactions and register writes, predicts each palette result.
// Depends on cldc_pkg and color_light_dark_classifier.
module tb_top import cldc_pkg::*; ();

  localparam int CNT_BITS = COUNT_BITS_DEFAULT;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  // Timeout bound for the slowest run (every colour a result under the longest stalls)
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 120;
  localparam int LONG_HOLD = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;

  color_light_dark_classifier #(.COUNT_BITS(CNT_BITS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Predictor copy of registers and accumulators
  logic [7:0]          floor_q;
  logic [15:0]         hue_lim;
  logic [15:0]         sat_lim;
  logic [CNT_BITS-1:0] acc_count;
  logic [15:0]         hue_lo, hue_hi, sat_lo, sat_hi;
  logic [SUM_W-1:0]    val_sum;

  in_t  pending[$];
  out_t palette_due[$];
  out_t want;
  int   err_count = 0;
  int   results_seen = 0;
  int   cycle_count = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   hold_left = 0;
  bit   idle_en = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void colour_to_hsv(input logic [31:0] c, output logic [15:0] hue,
                                        output logic [15:0] sat, output logic [7:0] top);
    int r, g, b, mx, mn, d, num, q;
    r = int'(c[23:16]);
    g = int'(c[15:8]);
    b = int'(c[7:0]);
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    hue = '0;
    sat = '0;
    if (mx != 0) begin
      q = (d * 65536) / mx;
      sat = (q > 65535) ? 16'hFFFF : 16'(q);
    end
    if (d != 0) begin
      // red wins ties, then green
      if (r == mx) num = HUE_SIXTH * (g - b);
      else if (g == mx) num = 2 * HUE_SIXTH * d + HUE_SIXTH * (b - r);
      else num = 4 * HUE_SIXTH * d + HUE_SIXTH * (r - g);
      if (num < 0) num += HUE_FULL * d;
      hue = 16'(num / d);
    end
    top = 8'(mx);
  endfunction

  task automatic clear_palette_acc();
    acc_count = '0;
    hue_lo = '0;
    hue_hi = '0;
    sat_lo = '0;
    sat_hi = '0;
    val_sum = '0;
  endtask

  task automatic absorb_colour(input logic [31:0] c);
    logic [15:0] hue, sat;
    logic [7:0]  top;
    longint      s;
    colour_to_hsv(c, hue, sat, top);
    if (acc_count == 0) begin
      hue_lo = hue;
      hue_hi = hue;
      sat_lo = sat;
      sat_hi = sat;
    end else begin
      if (hue < hue_lo) hue_lo = hue;
      if (hue > hue_hi) hue_hi = hue;
      if (sat < sat_lo) sat_lo = sat;
      if (sat > sat_hi) sat_hi = sat;
    end
    // a saturated count freezes the sum but not the extremes
    if (acc_count != '1) begin
      s = longint'(val_sum) + longint'(top);
      val_sum = (s > longint'({SUM_W{1'b1}})) ? {SUM_W{1'b1}} : SUM_W'(s);
      acc_count = acc_count + 1'b1;
    end
  endtask

  task automatic take_colour(input in_t it);
    out_t res;
    if (it.color[31:24] >= floor_q) absorb_colour(it.color);
    if (it.last) begin
      res.sampled_count = (longint'(acc_count) > 65535) ? 16'hFFFF : 16'(acc_count);
      if (acc_count == 0) res.palette = PAL_UNKNOWN;
      else if ((hue_hi - hue_lo) > hue_lim || (sat_hi - sat_lo) > sat_lim)
        res.palette = PAL_UNKNOWN;
      else if (longint'(val_sum) * 2 >= 255 * longint'(acc_count)) res.palette = PAL_LIGHT;
      else res.palette = PAL_DARK;
      palette_due.push_back(res);
      clear_palette_acc();
    end
  endtask

  // Driver: offer queued colours, predict at each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) take_colour(in_data);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else begin
          in_data <= pending.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare results, drive stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen = results_seen + 1;
        if (palette_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual palette %0d count %0d",
                   $time, out_data.palette, out_data.sampled_count);
          err_count++;
        end else begin
          want = palette_due.pop_front();
          if (out_data.palette !== want.palette) begin
            $display("%0t: palette mismatch: expected %0d, actual %0d",
                     $time, want.palette, out_data.palette);
            err_count++;
          end
          if (out_data.sampled_count !== want.sampled_count) begin
            $display("%0t: sampled_count mismatch: expected %0d, actual %0d",
                     $time, want.sampled_count, out_data.sampled_count);
            err_count++;
          end
        end
        // hold off long enough for the input side to back up
        if (idle_en && (results_seen == 30 || results_seen == 150)) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ALPHA_FLOOR: floor_q = val[7:0];
      CFG_HUE_SPREAD:  hue_lim = val;
      CFG_SAT_SPREAD:  sat_lim = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [15:0] fl, input logic [15:0] hl,
                            input logic [15:0] sl);
    write_reg(CFG_ALPHA_FLOOR, fl);
    write_reg(CFG_HUE_SPREAD, hl);
    write_reg(CFG_SAT_SPREAD, sl);
  endtask

  // Wait for every transaction to be accepted and every result to arrive
  task automatic drain();
    forever begin
      @(posedge clk);
      if (pending.size() == 0 && !in_valid && palette_due.size() == 0) break;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_colour(input logic [31:0] c, input logic lst);
    in_t it;
    it.color = c;
    it.last = lst;
    pending.push_back(it);
  endtask

  function automatic logic [7:0] nudge(input int base);
    int v;
    v = base + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [7:0] pick_alpha();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(int'(floor_q), 255));
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly near-uniform palettes so light and dark both show up; some noise
  task automatic queue_set(input int len, input bit uniform);
    int r0, g0, b0, k;
    logic [31:0] c;
    r0 = $urandom_range(0, 255);
    g0 = $urandom_range(0, 255);
    b0 = $urandom_range(0, 255);
    for (k = 0; k < len; k++) begin
      if (uniform) c = {pick_alpha(), nudge(r0), nudge(g0), nudge(b0)};
      else c = $urandom;
      queue_colour(c, k == len - 1);
    end
  endtask

  task automatic random_phase(input int n);
    int done_items, len;
    done_items = 0;
    while (done_items < n) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      queue_set(len, $urandom_range(0, 9) < 7);
      done_items += len;
    end
    drain();
  endtask

  initial begin
    int k;
    floor_q = ALPHA_FLOOR_RST;
    hue_lim = HUE_SPREAD_RST;
    sat_lim = SAT_SPREAD_RST;
    clear_palette_acc();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed sets under reset register values
    queue_colour(32'h00FFFFFF, 1'b1);   // nothing sampled
    queue_colour(32'hFFFFFFFF, 1'b1);   // white
    queue_colour(32'hFF000000, 1'b1);   // black, zero max
    queue_colour(32'hFFFF0000, 1'b1);
    queue_colour(32'hFF00FF00, 1'b1);
    queue_colour(32'hFF0000FF, 1'b1);
    queue_colour(32'hFFFF0010, 1'b1);   // negative hue wraps
    queue_colour(32'hFFC8C810, 1'b1);   // red and green tie
    queue_colour(32'hFF10C8C8, 1'b1);   // green and blue tie
    queue_colour(32'hFFFF00FF, 1'b1);   // red and blue tie
    queue_colour(32'h4B808080, 1'b1);   // alpha on the floor, brightness just light
    queue_colour(32'h4A808080, 1'b0);   // just below the floor
    queue_colour(32'hFF7F7F7F, 1'b1);   // just dark
    queue_colour(32'hFFFF0000, 1'b0);
    queue_colour(32'hFF00FF00, 1'b1);   // hue spread too wide
    queue_colour(32'hFF808080, 1'b0);
    queue_colour(32'hFFFF8080, 1'b1);   // saturation spread too wide
    queue_colour(32'hFF010000, 1'b1);   // saturation clamps
    drain();

    set_limits(16'd0, 16'd46080, 16'd65535);
    random_phase(250);
    set_limits(16'd255, 16'd0, 16'd0);
    random_phase(200);
    // Unused index is ignored; upper bits of the floor write are dropped
    write_reg(CFG_UNUSED, 16'h0000);
    set_limits(16'hFF80, HUE_SPREAD_RST, SAT_SPREAD_RST);
    random_phase(250);
    for (k = 0; k < 3; k++) begin
      set_limits(16'($urandom), 16'($urandom_range(0, 46080)), 16'($urandom));
      random_phase(250);
    end

    // Last stretch runs without idling on either side
    idle_en = 1'b0;
    set_limits(16'($urandom_range(0, 120)), 16'($urandom_range(0, 46080)), 16'($urandom));
    random_phase(250);

    if (err_count == 0 && palette_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
